>>> sv/tiba_pkg.sv
package tiba_pkg;

  // Default build parameters
  localparam int POSITIONS_DEF   = 65536;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field formats
  localparam int POS_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 8;
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = 16;
  localparam int LP_FRAC   = 8;

  // APB register port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Registers from accept to output register, inclusive
  localparam int PIPE_DEPTH = 7;

  typedef enum logic [2:0] {
    REG_HI_NUM0 = 3'd0,
    REG_HI_NUM1 = 3'd1,
    REG_HI_DEN1 = 3'd2,
    REG_LO_NUM0 = 3'd3,
    REG_LO_NUM1 = 3'd4,
    REG_LO_DEN1 = 3'd5
  } cfg_reg_e;

endpackage

>>> sv/tiba_if.sv
// Input channel: one pyramid coefficient per transaction
interface tiba_in_if import tiba_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [POS_W-1:0]              position;
  logic                          first_frame;
  logic [GAIN_W-1:0]             band_gain;

  modport source (output valid, sample, position, first_frame, band_gain, input ready);
  modport sink   (input valid, sample, position, first_frame, band_gain, output ready);
endinterface

// Output channel: one amplified coefficient per transaction
interface tiba_out_if import tiba_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] amplified;
  logic [POS_W-1:0]              out_position;

  modport source (output valid, amplified, out_position, input ready);
  modport sink   (input valid, amplified, out_position, output ready);
endinterface

>>> sv/tiba_store.sv
// Per-position state store: one write port, one registered read port
module tiba_store #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 40
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

>>> sv/temporal_iir_bandpass_amplify.sv
// Channel   Direction  Payload                                      Handshake
// in_i      sink       sample, position, first_frame, band_gain     valid/ready
// out_o     source     amplified, out_position                      valid/ready
// APB       slave      six coefficient registers at 4*i             psel/penable
//
// One transaction per cycle unless out_o stalls or a same-position hazard holds.
// Two back-to-back transactions on the same position cost one bubble: the
// state store read-modify-write loop closes through the filter stage.
// Reset clears control and the coefficient registers; the state store is not
// cleared, each position is seeded by its first-frame transaction.
// A stall on out_o freezes the whole pipeline; nothing is dropped or repeated.
module temporal_iir_bandpass_amplify import tiba_pkg::*; #(
  parameter int POSITIONS   = POSITIONS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  tiba_in_if.sink           in_i,
  tiba_out_if.source        out_o
);

  localparam int SB      = SAMPLE_BITS;
  localparam int LP_W    = SB + LP_FRAC;
  localparam int IDX_W   = $clog2(POSITIONS);
  localparam int MEM_W   = 2 * LP_W + SB;
  localparam int P0_W    = COEF_W + SB;
  localparam int PD_W    = COEF_W + LP_W;
  localparam int ACC_W   = PD_W + 3;
  localparam int DIFF_W  = LP_W + 1;
  localparam int GPROD_W = DIFF_W + GAIN_W + 1;
  localparam int OACC_W  = GPROD_W + 1;
  localparam int OUT_SH  = LP_FRAC + GAIN_FRAC;

  localparam logic signed [ACC_W-1:0]  RND_LP  = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0]  LP_MAX  = (ACC_W'(1) <<< (LP_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0]  LP_MIN  = -LP_MAX - ACC_W'(1);
  localparam logic signed [OACC_W-1:0] RND_OUT = OACC_W'(1) <<< (OUT_SH - 1);
  localparam logic signed [OACC_W-1:0] OUT_MAX = (OACC_W'(1) <<< (SB - 1)) - OACC_W'(1);
  localparam logic signed [OACC_W-1:0] OUT_MIN = -OUT_MAX - OACC_W'(1);

  // ---------------------------------------------------------------------------
  // Coefficient registers
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0] hi_num0_q, hi_num1_q, hi_den1_q;
  logic signed [COEF_W-1:0] lo_num0_q, lo_num1_q, lo_den1_q;
  logic                     cfg_wr;
  cfg_reg_e                 cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_num0_q <= '0;
      hi_num1_q <= '0;
      hi_den1_q <= '0;
      lo_num0_q <= '0;
      lo_num1_q <= '0;
      lo_den1_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_HI_NUM0: hi_num0_q <= pwdata[COEF_W-1:0];
        REG_HI_NUM1: hi_num1_q <= pwdata[COEF_W-1:0];
        REG_HI_DEN1: hi_den1_q <= pwdata[COEF_W-1:0];
        REG_LO_NUM0: lo_num0_q <= pwdata[COEF_W-1:0];
        REG_LO_NUM1: lo_num1_q <= pwdata[COEF_W-1:0];
        REG_LO_DEN1: lo_den1_q <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_HI_NUM0: prdata = APB_DW'(hi_num0_q);
      REG_HI_NUM1: prdata = APB_DW'(hi_num1_q);
      REG_HI_DEN1: prdata = APB_DW'(hi_den1_q);
      REG_LO_NUM0: prdata = APB_DW'(lo_num0_q);
      REG_LO_NUM1: prdata = APB_DW'(lo_num1_q);
      REG_LO_DEN1: prdata = APB_DW'(lo_den1_q);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------------
  logic adv, hazard, front_en;
  logic s1_valid_q, s2_valid_q, sa_valid_q, sb_valid_q, sc_valid_q, sd_valid_q;
  logic out_valid_q;
  logic [IDX_W-1:0] s2_idx, sa_idx_q, sb_idx_q, sc_idx_q;

  // back half moves whenever the output register frees up
  assign adv      = !out_valid_q || out_o.ready;
  // same position right behind: let the older one reach the write stage first
  assign hazard   = s2_valid_q && sa_valid_q && (s2_idx == sa_idx_q);
  assign front_en = adv && !hazard;
  assign in_i.ready = front_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      sa_valid_q  <= 1'b0;
      sb_valid_q  <= 1'b0;
      sc_valid_q  <= 1'b0;
      sd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (front_en) begin
        s1_valid_q <= in_i.valid;
        s2_valid_q <= s1_valid_q;
      end
      if (adv) begin
        sa_valid_q  <= s2_valid_q && !hazard;
        sb_valid_q  <= sa_valid_q;
        sc_valid_q  <= sb_valid_q;
        sd_valid_q  <= sc_valid_q;
        out_valid_q <= sd_valid_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1-2: capture and store index (position modulo depth)
  // ---------------------------------------------------------------------------
  logic signed [SB-1:0] s1_x_q, s2_x_q;
  logic [POS_W-1:0]     s1_pos_q, s2_pos_q;
  logic                 s1_first_q, s2_first_q;
  logic [GAIN_W-1:0]    s1_gain_q, s2_gain_q;

  always_ff @(posedge clk_i) begin
    if (front_en) begin
      s1_x_q     <= in_i.sample;
      s1_pos_q   <= in_i.position;
      s1_first_q <= in_i.first_frame;
      s1_gain_q  <= in_i.band_gain;
      s2_x_q     <= s1_x_q;
      s2_pos_q   <= s1_pos_q;
      s2_first_q <= s1_first_q;
      s2_gain_q  <= s1_gain_q;
    end
  end

  if (POSITIONS < (1 << POS_W)) begin : g_mod
    // reciprocal estimate may come out one low; one compare-subtract fixes it
    localparam int CW      = $clog2(POSITIONS);
    localparam int RECIP_W = 34 - CW;
    localparam int QP_W    = POS_W + RECIP_W;
    localparam int Q_W     = QP_W - 32;
    localparam int QM_W    = Q_W + CW;
    localparam longint unsigned RECIP_L = (64'd1 << 32) / POSITIONS;
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_L);
    localparam logic [POS_W:0]     MODULUS = (POS_W + 1)'(POSITIONS);

    logic [QP_W-1:0]  qprod_q;
    logic [POS_W-1:0] qmul_q;
    logic [POS_W:0]   rem, rem_fix;

    always_ff @(posedge clk_i) begin
      if (front_en) begin
        qprod_q <= QP_W'(in_i.position) * QP_W'(RECIP);
        qmul_q  <= POS_W'(QM_W'(qprod_q[QP_W-1:32]) * QM_W'(POSITIONS));
      end
    end

    always_comb begin
      rem     = {1'b0, s2_pos_q} - {1'b0, qmul_q};
      rem_fix = (rem >= MODULUS) ? (rem - MODULUS) : rem;
      s2_idx  = rem_fix[IDX_W-1:0];
    end
  end else begin : g_direct
    assign s2_idx = IDX_W'(s2_pos_q);
  end

  // ---------------------------------------------------------------------------
  // State store
  // ---------------------------------------------------------------------------
  logic             st_we;
  logic [MEM_W-1:0] st_wdata, st_rdata;

  tiba_store #(
    .DEPTH (POSITIONS),
    .WIDTH (MEM_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_we),
    .wr_addr_i (sb_idx_q),
    .wr_data_i (st_wdata),
    .rd_en_i   (front_en),
    .rd_addr_i (s2_idx),
    .rd_data_o (st_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage A: forward from stage C, six coefficient products
  // ---------------------------------------------------------------------------
  logic signed [SB-1:0]   sa_x_q, sb_x_q, sc_x_q;
  logic [POS_W-1:0]       sa_pos_q, sb_pos_q, sc_pos_q, sd_pos_q;
  logic                   sa_first_q, sb_first_q;
  logic [GAIN_W-1:0]      sa_gain_q, sb_gain_q, sc_gain_q;
  logic signed [LP_W-1:0] sc_hi_q, sc_lo_q;

  logic                   fwd;
  logic signed [LP_W-1:0] y_hi, y_lo;
  logic signed [SB-1:0]   x_prev;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_x_q     <= s2_x_q;
      sa_pos_q   <= s2_pos_q;
      sa_idx_q   <= s2_idx;
      sa_first_q <= s2_first_q;
      sa_gain_q  <= s2_gain_q;
    end
  end

  // stage C holds the transaction whose write met this read on the same edge
  always_comb begin
    fwd    = sc_valid_q && (sc_idx_q == sa_idx_q);
    y_hi   = fwd ? sc_hi_q : st_rdata[MEM_W-1 -: LP_W];
    y_lo   = fwd ? sc_lo_q : st_rdata[SB +: LP_W];
    x_prev = fwd ? sc_x_q  : st_rdata[SB-1:0];
  end

  logic signed [P0_W-1:0] p_hi0_q, p_hi1_q, p_lo0_q, p_lo1_q;
  logic signed [PD_W-1:0] p_hid_q, p_lod_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_hi0_q    <= P0_W'(hi_num0_q) * P0_W'(sa_x_q);
      p_hi1_q    <= P0_W'(hi_num1_q) * P0_W'(x_prev);
      p_hid_q    <= PD_W'(hi_den1_q) * PD_W'(y_hi);
      p_lo0_q    <= P0_W'(lo_num0_q) * P0_W'(sa_x_q);
      p_lo1_q    <= P0_W'(lo_num1_q) * P0_W'(x_prev);
      p_lod_q    <= PD_W'(lo_den1_q) * PD_W'(y_lo);
      sb_x_q     <= sa_x_q;
      sb_pos_q   <= sa_pos_q;
      sb_idx_q   <= sa_idx_q;
      sb_first_q <= sa_first_q;
      sb_gain_q  <= sa_gain_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: sum, round half up, saturate (or seed on first frame); write back
  // ---------------------------------------------------------------------------
  function automatic logic signed [LP_W-1:0] lp_finish(
    input logic signed [P0_W-1:0] a,
    input logic signed [P0_W-1:0] b,
    input logic signed [PD_W-1:0] d
  );
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] sh;
    acc = (ACC_W'(a) <<< LP_FRAC) + (ACC_W'(b) <<< LP_FRAC) - ACC_W'(d) + RND_LP;
    sh  = acc >>> COEF_FRAC;
    if (sh > LP_MAX) begin
      sh = LP_MAX;
    end else if (sh < LP_MIN) begin
      sh = LP_MIN;
    end
    return sh[LP_W-1:0];
  endfunction

  logic signed [LP_W-1:0] hi_d, lo_d, seed;

  always_comb begin
    seed = LP_W'(sb_x_q) <<< LP_FRAC;
    if (sb_first_q) begin
      hi_d = seed;
      lo_d = seed;
    end else begin
      hi_d = lp_finish(p_hi0_q, p_hi1_q, p_hid_q);
      lo_d = lp_finish(p_lo0_q, p_lo1_q, p_lod_q);
    end
  end

  assign st_we    = adv && sb_valid_q;
  assign st_wdata = {hi_d, lo_d, sb_x_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_hi_q   <= hi_d;
      sc_lo_q   <= lo_d;
      sc_x_q    <= sb_x_q;
      sc_pos_q  <= sb_pos_q;
      sc_idx_q  <= sb_idx_q;
      sc_gain_q <= sb_gain_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: band-pass difference times gain
  // ---------------------------------------------------------------------------
  logic signed [DIFF_W-1:0]  diff;
  logic signed [GPROD_W-1:0] sd_prod_q;

  assign diff = DIFF_W'(sc_hi_q) - DIFF_W'(sc_lo_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_prod_q <= GPROD_W'(diff) * GPROD_W'($signed({1'b0, sc_gain_q}));
      sd_pos_q  <= sc_pos_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: round half up, saturate to sample range, output register
  // ---------------------------------------------------------------------------
  logic signed [OACC_W-1:0] oacc, osh;
  logic signed [SB-1:0]     amp_d, amp_q;
  logic [POS_W-1:0]         opos_q;

  always_comb begin
    oacc = OACC_W'(sd_prod_q) + RND_OUT;
    osh  = oacc >>> OUT_SH;
    if (osh > OUT_MAX) begin
      amp_d = OUT_MAX[SB-1:0];
    end else if (osh < OUT_MIN) begin
      amp_d = OUT_MIN[SB-1:0];
    end else begin
      amp_d = osh[SB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      amp_q  <= amp_d;
      opos_q <= sd_pos_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.amplified    = amp_q;
  assign out_o.out_position = opos_q;

endmodule

>>> sv/tiba_checker.sv
// Port-level checks for the band-pass amplifier
module tiba_checker import tiba_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_amplified,
  input logic [POS_W-1:0]       out_pos
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] inflight_q;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_amplified) && $stable(out_pos))
    else $error("result changed while stalled");

  // no result without an accepted transaction behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> inflight_q != '0)
    else $error("result with nothing in flight");

  // pipeline never holds more than its register count
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(PIPE_DEPTH))
    else $error("too many transactions in flight");

  // input only opens when the pipeline can move
  a_ready_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !out_valid || out_ready)
    else $error("input ready while output blocked");

endmodule

bind temporal_iir_bandpass_amplify tiba_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_tiba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .out_amplified (out_o.amplified),
  .out_pos       (out_o.out_position)
);
